### rtl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants for the sensor-to-servo change filter
// Register codes, configuration bundle, front-to-back job record.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int DATA_W       = 12;   // sample, pulse and register width
  localparam int CH_IN_W      = 3;    // channel field width
  localparam int CFG_IDX_W    = 3;    // register index width
  localparam int CHANNELS_DEF = 5;
  localparam int NUM_W        = 2 * DATA_W;  // numerator width handed to divider
  localparam int Q_DEPTH      = 2;    // job queue depth, power of two
  localparam int Q_AW         = $clog2(Q_DEPTH);

  // floor(v / 100) == (v * 5243) >> 19 for every 12-bit v
  localparam int QUANTUM      = 100;
  localparam int RECIP        = 5243;
  localparam int RECIP_SHIFT  = 19;
  localparam int PROD_W       = 25;

  localparam logic [DATA_W-1:0] RST_IN_LOW       = DATA_W'(1000);
  localparam logic [DATA_W-1:0] RST_IN_HIGH      = DATA_W'(4095);
  localparam logic [DATA_W-1:0] RST_PULSE_LOW    = DATA_W'(500);
  localparam logic [DATA_W-1:0] RST_PULSE_HIGH   = DATA_W'(2500);
  localparam logic [DATA_W-1:0] RST_CHANGE_LIMIT = DATA_W'(100);

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_LOW       = 3'd0,
    REG_IN_HIGH      = 3'd1,
    REG_PULSE_LOW    = 3'd2,
    REG_PULSE_HIGH   = 3'd3,
    REG_CHANGE_LIMIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    word_t in_low;
    word_t in_high;
    word_t pulse_low;
    word_t pulse_high;
    word_t change_limit;
  } cfg_t;

  typedef struct packed {
    logic [CH_IN_W-1:0] channel;
    logic               use_pl;  // degenerate range or negative numerator
    logic               sat;     // quotient would exceed 12 bits
    logic [NUM_W-1:0]   num;
    word_t              den;
  } job_t;

endpackage

### rtl/scf_if.sv
// ----------------------------------------------------------------------------
// scf_if: channel interfaces
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface scf_in_if;
  logic                         valid;
  logic                         ready;
  logic [scf_pkg::CH_IN_W-1:0]  channel;
  logic [scf_pkg::DATA_W-1:0]   sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface scf_out_if;
  logic                         valid;
  logic                         ready;
  logic [scf_pkg::CH_IN_W-1:0]  channel_out;
  logic [scf_pkg::DATA_W-1:0]   pulse;
  logic                         updated;

  modport source (output valid, channel_out, pulse, updated, input ready);
  modport sink   (input valid, channel_out, pulse, updated, output ready);
endinterface

interface scf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scf_pkg::CFG_IDX_W-1:0] index;
  logic [scf_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/scf_front.sv
// ----------------------------------------------------------------------------
// scf_front: sample intake and numerator build
// Accepts a beat, forms the mapping numerator in multiply and add steps and
// classifies it (clamp low, saturate, or divide) before queuing the job.
// ----------------------------------------------------------------------------
module scf_front (
  input  logic            clk,
  input  logic            rst_n,
  scf_in_if.sink          in_s,
  input  scf_pkg::cfg_t   cfg,
  output scf_pkg::job_t   job,
  output logic            job_valid,
  input  logic            job_ready
);
  import scf_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_ADD, F_PUSH} fstate_t;

  fstate_t                state_r, state_nxt;
  logic [CH_IN_W-1:0]     ch_r, ch_nxt;
  logic signed [DATA_W:0] dx_r, dx_nxt;     // sample - in_low
  logic signed [DATA_W:0] dp_r, dp_nxt;     // pulse_high - pulse_low
  logic signed [DATA_W:0] den_r, den_nxt;   // in_high - in_low
  logic                   degen_r, degen_nxt;
  logic signed [2*DATA_W+1:0] p1_r, p1_nxt;
  logic [2*DATA_W-1:0]    p2_r, p2_nxt;
  logic signed [2*DATA_W+2:0] num_r, num_nxt;

  assign in_s.ready = (state_r == F_IDLE);
  assign job_valid  = (state_r == F_PUSH);

  always_comb begin
    job.channel = ch_r;
    job.use_pl  = degen_r | num_r[2*DATA_W+2];
    job.sat     = $unsigned(num_r) >= {3'b000, den_r[DATA_W-1:0], {DATA_W{1'b0}}};
    job.num     = num_r[NUM_W-1:0];
    job.den     = den_r[DATA_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    dx_nxt    = dx_r;
    dp_nxt    = dp_r;
    den_nxt   = den_r;
    degen_nxt = degen_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    num_nxt   = num_r;
    case (state_r)
      F_IDLE: begin
        if (in_s.valid) begin
          ch_nxt    = in_s.channel;
          dx_nxt    = $signed({1'b0, in_s.sample}) - $signed({1'b0, cfg.in_low});
          dp_nxt    = $signed({1'b0, cfg.pulse_high}) - $signed({1'b0, cfg.pulse_low});
          den_nxt   = $signed({1'b0, cfg.in_high}) - $signed({1'b0, cfg.in_low});
          degen_nxt = (cfg.in_high <= cfg.in_low);
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        p1_nxt    = dx_r * dp_r;
        p2_nxt    = cfg.pulse_low * den_r[DATA_W-1:0];
        state_nxt = F_ADD;
      end
      F_ADD: begin
        num_nxt   = p1_r + $signed({3'b000, p2_r});
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ch_r    <= ch_nxt;
    dx_r    <= dx_nxt;
    dp_r    <= dp_nxt;
    den_r   <= den_nxt;
    degen_r <= degen_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    num_r   <= num_nxt;
  end

  // one sample in flight in the front at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready) |=> !in_s.ready)
    else $error("front accepted a beat while busy");

endmodule

### rtl/scf_queue.sv
// ----------------------------------------------------------------------------
// scf_queue: job queue between front and back
// Small FIFO so the front can build the next numerator while the back divides.
// ----------------------------------------------------------------------------
module scf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  scf_pkg::job_t push_job,
  input  logic          push_valid,
  output logic          push_ready,
  output scf_pkg::job_t pop_job,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import scf_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("job queue count over depth");

endmodule

### rtl/scf_back.sv
// ----------------------------------------------------------------------------
// scf_back: divide, clamp, quantize and change decision
// Restoring divider (one quotient bit per cycle), clamp, round down to a
// multiple of 100, compare with last value sent, then the output register.
// ----------------------------------------------------------------------------
module scf_back #(
  parameter int CHANNELS = scf_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scf_pkg::cfg_t cfg,
  input  scf_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  scf_out_if.source     out_m
);
  import scf_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(DATA_W + 1);

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_CLAMP, B_Q1, B_Q2, B_DEC, B_OUT} bstate_t;

  bstate_t            state_r, state_nxt;
  logic [CH_IN_W-1:0] ch_r, ch_nxt;
  logic               ok_r, ok_nxt;
  word_t              den_r, den_nxt;
  word_t              rem_r, rem_nxt;
  word_t              quo_r, quo_nxt;   // numerator low bits shift out, quotient in
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  word_t              v_r, v_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  word_t              m_r, m_nxt;
  logic               upd_r, upd_nxt;
  word_t              last_r [CHANNELS];

  logic               out_valid_r, out_valid_nxt;
  logic [CH_IN_W-1:0] out_ch_r, out_ch_nxt;
  word_t              out_pulse_r, out_pulse_nxt;
  logic               out_upd_r, out_upd_nxt;

  logic [7:0]         job_ch_ext, ch_ext;
  logic [IDX_W-1:0]   idx;
  logic [DATA_W:0]    trial;
  word_t              lo_clamp, prev, diff;
  logic               out_load;

  assign job_ch_ext = {{(8-CH_IN_W){1'b0}}, job.channel};
  assign ch_ext     = {{(8-CH_IN_W){1'b0}}, ch_r};
  assign idx        = ch_ext[IDX_W-1:0];
  assign prev       = ok_r ? last_r[idx] : '0;
  assign trial      = {rem_r, quo_r[DATA_W-1]};
  assign lo_clamp   = (quo_r < cfg.pulse_low) ? cfg.pulse_low : quo_r;
  assign diff       = (m_r > prev) ? (m_r - prev) : (prev - m_r);
  assign out_load   = (state_r == B_OUT) && (!out_valid_r || out_m.ready);

  assign job_ready     = (state_r == B_IDLE);
  assign out_m.valid   = out_valid_r;
  assign out_m.channel_out = out_ch_r;
  assign out_m.pulse   = out_pulse_r;
  assign out_m.updated = out_upd_r;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    ok_nxt    = ok_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    v_nxt     = v_r;
    prod_nxt  = prod_r;
    m_nxt     = m_r;
    upd_nxt   = upd_r;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          ch_nxt  = job.channel;
          ok_nxt  = job_ch_ext < 8'(CHANNELS);
          den_nxt = job.den;
          cnt_nxt = '0;
          if (job.use_pl) begin
            quo_nxt   = cfg.pulse_low;
            state_nxt = B_CLAMP;
          end else if (job.sat) begin
            quo_nxt   = '1;        // anything above 4095 clamps to pulse_high
            state_nxt = B_CLAMP;
          end else begin
            rem_nxt   = job.num[NUM_W-1:DATA_W];
            quo_nxt   = job.num[DATA_W-1:0];
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = DATA_W'(trial - {1'b0, den_r});
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) state_nxt = B_CLAMP;
      end
      B_CLAMP: begin
        // lower clamp first, then upper: inverted range ends at pulse_high
        v_nxt     = (lo_clamp > cfg.pulse_high) ? cfg.pulse_high : lo_clamp;
        state_nxt = B_Q1;
      end
      B_Q1: begin
        prod_nxt  = PROD_W'(v_r) * PROD_W'(RECIP);
        state_nxt = B_Q2;
      end
      B_Q2: begin
        m_nxt     = DATA_W'(prod_r[PROD_W-1:RECIP_SHIFT]) * DATA_W'(QUANTUM);
        state_nxt = B_DEC;
      end
      B_DEC: begin
        upd_nxt   = ok_r && (diff > cfg.change_limit);
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ch_nxt    = out_ch_r;
    out_pulse_nxt = out_pulse_r;
    out_upd_nxt   = out_upd_r;
    if (out_valid_r && out_m.ready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_ch_nxt    = ch_r;
      out_pulse_nxt = upd_r ? m_r : '0;
      out_upd_nxt   = upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) last_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_load && upd_r) last_r[idx] <= m_r;
    end
    ch_r        <= ch_nxt;
    ok_r        <= ok_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    v_r         <= v_nxt;
    prod_r      <= prod_nxt;
    m_r         <= m_nxt;
    upd_r       <= upd_nxt;
    out_ch_r    <= out_ch_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_upd_r   <= out_upd_nxt;
  end

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (cnt_r < CNT_W'(DATA_W)))
    else $error("divider ran past its last step");

  a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_upd_r) |-> (out_pulse_r == '0))
    else $error("pulse nonzero on a beat without update");

endmodule

### rtl/sensor_to_servo_change_filter.sv
// ----------------------------------------------------------------------------
// sensor_to_servo_change_filter: top level
// Maps a sensor sample onto a servo pulse range, quantizes it to steps of
// 100 and passes it on only when it moved more than change_limit.
// ----------------------------------------------------------------------------
//  port    dir   beat contents
//  in_s    in    channel, sample
//  out_m   out   channel_out, pulse, updated (one beat per input beat)
//  cfg_s   in    index, data (register write, always ready)
//
//  The front takes a new beat only once its job is queued; the back takes
//  one job at a time, through the 12-step restoring divider unless the
//  value clamps without it. The divider sets the sustained rate.
//  rst_n is synchronous: registers return to defaults, last-sent values to 0.
//  A 2-deep job queue and the output register let each side stall alone.
// ----------------------------------------------------------------------------
module sensor_to_servo_change_filter #(
  parameter int CHANNELS = scf_pkg::CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  scf_in_if.sink    in_s,
  scf_out_if.source out_m,
  scf_cfg_if.sink   cfg_s
);
  import scf_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t front_job, back_job;
  logic front_valid, front_ready, back_valid, back_ready;

  assign cfg_s.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_s.valid) begin
      case (cfg_reg_t'(cfg_s.index))
        REG_IN_LOW:       cfg_nxt.in_low       = cfg_s.data;
        REG_IN_HIGH:      cfg_nxt.in_high      = cfg_s.data;
        REG_PULSE_LOW:    cfg_nxt.pulse_low    = cfg_s.data;
        REG_PULSE_HIGH:   cfg_nxt.pulse_high   = cfg_s.data;
        REG_CHANGE_LIMIT: cfg_nxt.change_limit = cfg_s.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_low       <= RST_IN_LOW;
      cfg_r.in_high      <= RST_IN_HIGH;
      cfg_r.pulse_low    <= RST_PULSE_LOW;
      cfg_r.pulse_high   <= RST_PULSE_HIGH;
      cfg_r.change_limit <= RST_CHANGE_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  scf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .cfg       (cfg_r),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  scf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  scf_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .out_m     (out_m)
  );

endmodule
